>>> rtl/core/im2row_copy_descriptor_generator_assert.svh
// assertion macros shared by the checker of the descriptor generator
// no dependencies; expects clk and rst_n in the scope of use
`ifndef IM2ROW_COPY_DESCRIPTOR_GENERATOR_ASSERT_SVH
`define IM2ROW_COPY_DESCRIPTOR_GENERATOR_ASSERT_SVH

// consequent checked in the same cycle
`define I2R_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define I2R_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/i2r_pkg.sv
// types, register map and small tables of the im2row descriptor generator
// no dependencies
`default_nettype none

package i2r_pkg;

    localparam int ADDR_W     = 48;
    localparam int PADDR_W    = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // register indexes, one 64-bit slot each
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd0;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [2:0] REG_CHANNELS     = 3'd2;
    localparam logic [2:0] REG_KERNEL_SIZE  = 3'd3;
    localparam logic [2:0] REG_ELEM_LOG2    = 3'd4;
    localparam logic [2:0] REG_SOURCE_BASE  = 3'd5;
    localparam logic [2:0] REG_DEST_BASE    = 3'd6;

    typedef struct packed {
        logic [7:0] batch_index;
        logic [9:0] out_row;
        logic [9:0] out_col;
    } pos_t;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [15:0]       length_bytes;
        logic              zero_fill;
        logic              last;
    } desc_t;

    // configuration after clamping plus values derived from it
    typedef struct packed {
        logic [10:0]       hc;
        logic [10:0]       wc;
        logic [10:0]       cc;
        logic [1:0]        pad;
        logic [1:0]        sh;
        logic [13:0]       pix_bytes;
        logic [21:0]       wcc;
        logic [16:0]       rowlen;
        logic [16:0]       run_len;
        logic [12:0]       padwp;
        logic [ADDR_W-1:0] src_base;
        logic [ADDR_W-1:0] dst_base;
    } cfg_t;

    // one classified position waiting for the back end
    typedef struct packed {
        logic [ADDR_W-1:0] dst_off;
        logic [ADDR_W-1:0] tl_off;
        logic              interior;
        logic [9:0]        out_row;
        logic [9:0]        out_col;
    } ent_t;

    // side squared for a given padding
    function automatic logic [5:0] sq_of_pad(input logic [1:0] pad);
        logic [5:0] sq;
        case (pad)
            2'd0:    sq = 6'd1;
            2'd1:    sq = 6'd9;
            2'd2:    sq = 6'd25;
            default: sq = 6'd49;
        endcase
        return sq;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/i2r_regs.sv
// configuration registers on the apb port and registered derived values
// depends on i2r_pkg
`default_nettype none

module i2r_regs #(
    parameter int MAX_KERNEL   = 7,
    parameter int MAX_DIM      = 1024,
    parameter int MAX_CHANNELS = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [i2r_pkg::PADDR_W-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    output logic      [63:0]                 prdata,
    output i2r_pkg::cfg_t                    cfg
);
    import i2r_pkg::*;

    localparam logic [1:0] PAD_MAX = 2'((MAX_KERNEL - 1) / 2);

    logic [10:0]       height_reg;
    logic [10:0]       width_reg;
    logic [10:0]       chan_reg;
    logic [2:0]        ksize_reg;
    logic [1:0]        elog2_reg;
    logic [ADDR_W-1:0] src_base_reg;
    logic [ADDR_W-1:0] dst_base_reg;
    cfg_t              cfg_reg;
    cfg_t              cfg_next;

    logic       wr;
    logic [2:0] idx;
    logic [1:0] pad_raw;
    logic [2:0] side;

    assign wr  = psel & penable & pwrite;
    assign idx = paddr[PADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg   <= 11'd1;
            width_reg    <= 11'd1;
            chan_reg     <= 11'd1;
            ksize_reg    <= 3'd3;
            elog2_reg    <= 2'd0;
            src_base_reg <= '0;
            dst_base_reg <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_IMAGE_HEIGHT: height_reg   <= pwdata[10:0];
                REG_IMAGE_WIDTH:  width_reg    <= pwdata[10:0];
                REG_CHANNELS:     chan_reg     <= pwdata[10:0];
                REG_KERNEL_SIZE:  ksize_reg    <= pwdata[2:0];
                REG_ELEM_LOG2:    elog2_reg    <= pwdata[1:0];
                REG_SOURCE_BASE:  src_base_reg <= pwdata[ADDR_W-1:0];
                REG_DEST_BASE:    dst_base_reg <= pwdata[ADDR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_IMAGE_HEIGHT: prdata = 64'(height_reg);
            REG_IMAGE_WIDTH:  prdata = 64'(width_reg);
            REG_CHANNELS:     prdata = 64'(chan_reg);
            REG_KERNEL_SIZE:  prdata = 64'(ksize_reg);
            REG_ELEM_LOG2:    prdata = 64'(elog2_reg);
            REG_SOURCE_BASE:  prdata = 64'(src_base_reg);
            REG_DEST_BASE:    prdata = 64'(dst_base_reg);
            default:          prdata = '0;
        endcase
    end

    // even sizes round down to odd, zero acts as 1, capped at the largest kernel
    always_comb
    begin
        pad_raw = (ksize_reg == 3'd0) ? 2'd0 : 2'((ksize_reg - 3'd1) >> 1);
        cfg_next.pad = (pad_raw > PAD_MAX) ? PAD_MAX : pad_raw;
        side = {cfg_next.pad, 1'b1};
        cfg_next.hc = (32'(height_reg) > 32'(MAX_DIM)) ? 11'(MAX_DIM) : height_reg;
        cfg_next.wc = (32'(width_reg) > 32'(MAX_DIM)) ? 11'(MAX_DIM) : width_reg;
        cfg_next.cc = (32'(chan_reg) > 32'(MAX_CHANNELS)) ? 11'(MAX_CHANNELS) : chan_reg;
        cfg_next.sh = elog2_reg;
        cfg_next.pix_bytes = 14'(cfg_next.cc) << elog2_reg;
        cfg_next.wcc = 22'(cfg_next.wc) * 22'(cfg_next.cc);
        cfg_next.rowlen = 17'(sq_of_pad(cfg_next.pad)) * 17'(cfg_next.cc);
        cfg_next.run_len = 17'(side) * 17'(cfg_next.pix_bytes);
        cfg_next.padwp = 13'(cfg_next.pad) * 13'(cfg_next.wc) + 13'(cfg_next.pad);
        cfg_next.src_base = src_base_reg;
        cfg_next.dst_base = dst_base_reg;
    end

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/i2r_front.sv
// front end: takes positions, computes base offsets and classifies the window
// depends on i2r_pkg
`default_nettype none

module i2r_front (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   pos_valid,
    output logic        pos_ready,
    input  wire i2r_pkg::pos_t pos,
    input  wire i2r_pkg::cfg_t cfg,
    output logic        ent_valid,
    output i2r_pkg::ent_t ent,
    input  wire logic   ent_full
);
    import i2r_pkg::*;

    logic en;

    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg;

    pos_t        a_pos_reg;
    logic [19:0] b_row_reg;
    logic [19:0] b_row_next;
    logic [9:0]  b_h_reg, b_w_reg;
    logic        b_int_reg;
    logic        b_int_next;
    logic [31:0] c_p0_reg;
    logic [31:0] c_p0_next;
    logic [9:0]  c_h_reg, c_w_reg;
    logic        c_int_reg;
    ent_t        d_ent_reg;
    ent_t        d_ent_next;

    logic [10:0]        h11, w11, pad11;
    logic signed [32:0] tl_pix;
    logic signed [44:0] tl_prod;

    // the whole pipe holds while its last stage cannot push
    assign en        = !d_v_reg || !ent_full;
    assign pos_ready = en;
    assign ent_valid = d_v_reg;
    assign ent       = d_ent_reg;

    always_comb
    begin
        h11   = {1'b0, a_pos_reg.out_row};
        w11   = {1'b0, a_pos_reg.out_col};
        pad11 = 11'(cfg.pad);
        b_row_next = 20'(a_pos_reg.batch_index) * 20'(cfg.hc) + 20'(a_pos_reg.out_row);
        b_int_next = (h11 >= pad11) && (h11 + pad11 < cfg.hc)
                  && (w11 >= pad11) && (w11 + pad11 < cfg.wc);
    end

    assign c_p0_next = 32'(b_row_reg) * 32'(cfg.wc) + 32'(b_w_reg);

    // top-left tap of the window in elements, may be negative at a border
    always_comb
    begin
        tl_pix  = $signed({1'b0, c_p0_reg}) - $signed({20'd0, cfg.padwp});
        tl_prod = tl_pix * $signed({1'b0, cfg.cc});
        d_ent_next.dst_off  = 48'(c_p0_reg) * 48'(cfg.rowlen);
        d_ent_next.tl_off   = {{3{tl_prod[44]}}, tl_prod};
        d_ent_next.interior = c_int_reg;
        d_ent_next.out_row  = c_h_reg;
        d_ent_next.out_col  = c_w_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= pos_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pos_reg <= pos;
            b_row_reg <= b_row_next;
            b_h_reg   <= a_pos_reg.out_row;
            b_w_reg   <= a_pos_reg.out_col;
            b_int_reg <= b_int_next;
            c_p0_reg  <= c_p0_next;
            c_h_reg   <= b_h_reg;
            c_w_reg   <= b_w_reg;
            c_int_reg <= b_int_reg;
            d_ent_reg <= d_ent_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/i2r_fifo.sv
// short queue of classified positions between front and back end
// depends on i2r_pkg
`default_nettype none

module i2r_fifo (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire i2r_pkg::ent_t push_data,
    output logic          full,
    input  wire logic     pop,
    output logic          nonempty,
    output i2r_pkg::ent_t pop_data
);
    import i2r_pkg::*;

    ent_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               do_push, do_pop;

    assign full     = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/i2r_back.sv
// back end: walks the kernel window and issues one descriptor a cycle unless desc_ready stalls
// depends on i2r_pkg
`default_nettype none

module i2r_back #(
    parameter int ADDR_BITS = 48
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire i2r_pkg::cfg_t cfg,
    input  wire logic      ent_valid,
    input  wire i2r_pkg::ent_t ent,
    output logic           ent_pop,
    output logic           desc_valid,
    input  wire logic      desc_ready,
    output i2r_pkg::desc_t desc
);
    import i2r_pkg::*;

    localparam int MASK_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - MASK_W);

    logic               act_reg;
    logic               out_v_reg;
    desc_t              out_reg;
    desc_t              out_next;
    logic               int_reg;
    logic [2:0]         ii_reg, jj_reg;
    logic signed [11:0] r_reg, c_reg, c0_reg;
    logic [ADDR_W-1:0]  row_reg, cur_reg, dst_reg;

    logic               gen, done, load;
    logic [2:0]         last_idx;
    logic               row_end, last_tap, tap_in;
    logic [ADDR_W-1:0]  src_off, src_full;
    logic [16:0]        step;
    logic [15:0]        len;
    logic signed [11:0] r_init, c_init;

    always_comb
    begin
        last_idx = {cfg.pad, 1'b0};
        row_end  = (jj_reg == last_idx);
        last_tap = (ii_reg == last_idx) && (int_reg || row_end);
        tap_in   = !r_reg[11] && (r_reg[10:0] < cfg.hc)
                && !c_reg[11] && (c_reg[10:0] < cfg.wc);
        src_off  = int_reg ? row_reg : cur_reg;
        src_full = cfg.src_base + (src_off << cfg.sh);
        // destination advances by the full run, the length field keeps 16 bits
        step     = int_reg ? cfg.run_len : 17'(cfg.pix_bytes);
        len      = step[15:0];

        out_next.src_addr     = (int_reg || tap_in) ? (src_full & ADDR_MASK) : '0;
        out_next.dst_addr     = dst_reg & ADDR_MASK;
        out_next.length_bytes = len;
        out_next.zero_fill    = !int_reg && !tap_in;
        out_next.last         = last_tap;

        r_init = $signed({2'b00, ent.out_row}) - $signed({10'd0, cfg.pad});
        c_init = $signed({2'b00, ent.out_col}) - $signed({10'd0, cfg.pad});
    end

    // the next queued position loads in the cycle the previous one ends
    assign gen     = act_reg && (!out_v_reg || desc_ready);
    assign done    = gen && last_tap;
    assign load    = ent_valid && (!act_reg || done);
    assign ent_pop = load;

    assign desc_valid = out_v_reg;
    assign desc       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                act_reg <= 1'b1;
            end
            else if (done)
            begin
                act_reg <= 1'b0;
            end
            if (gen)
            begin
                out_v_reg <= 1'b1;
            end
            else if (desc_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            out_reg <= out_next;
        end
        if (load)
        begin
            int_reg <= ent.interior;
            ii_reg  <= 3'd0;
            jj_reg  <= 3'd0;
            r_reg   <= r_init;
            c_reg   <= c_init;
            c0_reg  <= c_init;
            row_reg <= ent.tl_off;
            cur_reg <= ent.tl_off;
            dst_reg <= cfg.dst_base + (ent.dst_off << cfg.sh);
        end
        else if (gen && !last_tap)
        begin
            dst_reg <= dst_reg + 48'(step);
            if (int_reg)
            begin
                ii_reg  <= ii_reg + 3'd1;
                row_reg <= row_reg + 48'(cfg.wcc);
            end
            else if (row_end)
            begin
                // wrap to the first tap of the next kernel row
                ii_reg  <= ii_reg + 3'd1;
                jj_reg  <= 3'd0;
                r_reg   <= r_reg + 12'sd1;
                c_reg   <= c0_reg;
                row_reg <= row_reg + 48'(cfg.wcc);
                cur_reg <= row_reg + 48'(cfg.wcc);
            end
            else
            begin
                jj_reg  <= jj_reg + 3'd1;
                c_reg   <= c_reg + 12'sd1;
                cur_reg <= cur_reg + 48'(cfg.cc);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/im2row_copy_descriptor_generator.sv
// a position passes front stages a to d, the queue and the back-end walker before its first
//   descriptor is registered; throughput: one descriptor per cycle unless desc_ready stalls;
//   a position gives side descriptors if its window is inside the image, side*side at a border
//   (3 or 9 for a 3x3 kernel); a 4-entry queue lets positions enter while descriptors drain
// reset: rst_n clears all pipeline, queue and output control; registers return to defaults
// depends on i2r_pkg, i2r_regs, i2r_front, i2r_fifo, i2r_back
`default_nettype none

module im2row_copy_descriptor_generator #(
    parameter int MAX_KERNEL   = 7,
    parameter int MAX_DIM      = 1024,
    parameter int MAX_CHANNELS = 1024,
    parameter int ADDR_BITS    = 48
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pos_valid,
    output logic                             pos_ready,
    input  wire i2r_pkg::pos_t               pos,
    output logic                             desc_valid,
    input  wire logic                        desc_ready,
    output i2r_pkg::desc_t                   desc,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [i2r_pkg::PADDR_W-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    output logic      [63:0]                 prdata,
    output logic                             pready
);
    import i2r_pkg::*;

    cfg_t cfg;
    ent_t front_ent, fifo_ent;
    logic front_valid, fifo_full, fifo_nonempty, fifo_pop;

    assign pready = 1'b1;

    i2r_regs #(
        .MAX_KERNEL  (MAX_KERNEL),
        .MAX_DIM     (MAX_DIM),
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .cfg    (cfg)
    );

    i2r_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pos_valid(pos_valid),
        .pos_ready(pos_ready),
        .pos      (pos),
        .cfg      (cfg),
        .ent_valid(front_valid),
        .ent      (front_ent),
        .ent_full (fifo_full)
    );

    i2r_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_valid),
        .push_data(front_ent),
        .full     (fifo_full),
        .pop      (fifo_pop),
        .nonempty (fifo_nonempty),
        .pop_data (fifo_ent)
    );

    i2r_back #(
        .ADDR_BITS(ADDR_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ent_valid (fifo_nonempty),
        .ent       (fifo_ent),
        .ent_pop   (fifo_pop),
        .desc_valid(desc_valid),
        .desc_ready(desc_ready),
        .desc      (desc)
    );

endmodule

`default_nettype wire

>>> rtl/core/i2r_check.sv
// port-level checker for the im2row descriptor generator, with its bind
// depends on i2r_pkg and im2row_copy_descriptor_generator_assert.svh
`default_nettype none

`include "im2row_copy_descriptor_generator_assert.svh"

module i2r_check (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pos_valid,
    input  wire logic                        pos_ready,
    input  wire i2r_pkg::pos_t               pos,
    input  wire logic                        desc_valid,
    input  wire logic                        desc_ready,
    input  wire i2r_pkg::desc_t              desc,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [i2r_pkg::PADDR_W-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    input  wire logic [63:0]                 prdata,
    input  wire logic                        pready
);
    import i2r_pkg::*;

    logic wr_height, rd_height;

    assign wr_height = psel && penable && pwrite && pready
                    && (paddr == PADDR_W'(0));
    assign rd_height = psel && !pwrite && (paddr == PADDR_W'(0));

    `I2R_ASSERT_SAME(a_pready_high, 1'b1, pready, "pready dropped")

    `I2R_ASSERT_NEXT(a_desc_hold, desc_valid && !desc_ready,
        desc_valid && $stable(desc), "stalled descriptor changed")

    `I2R_ASSERT_SAME(a_zero_src, desc_valid && desc.zero_fill,
        desc.src_addr == '0, "zero-fill item with nonzero source")

    `I2R_ASSERT_SAME(a_readback, wr_height ##1 rd_height,
        prdata[10:0] == $past(pwdata[10:0]), "image_height readback mismatch")

    // keep unused inputs visible to lint
    logic unused_ok;
    assign unused_ok = pos_valid ^ pos_ready ^ (^pos);

endmodule

bind im2row_copy_descriptor_generator i2r_check u_check (.*);

`default_nettype wire

>>> dv/tb_im2row_copy_descriptor_generator.sv
// testbench for the im2row copy descriptor generator: positions in, descriptors out
// predicts every descriptor and checks it field by field in a small scoreboard class
// depends on i2r_pkg and im2row_copy_descriptor_generator
`timescale 1ns / 1ps

module tb_im2row_copy_descriptor_generator;
    import i2r_pkg::*;

    localparam int MAX_KERNEL     = 7;
    localparam int MAX_DIM        = 1024;
    localparam int MAX_CHANNELS   = 1024;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 20;
    // one slot past the register list, writes there must be ignored
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_mode_e;

    class desc_scoreboard;
        desc_t       due_descs[$];
        logic [10:0] height_r;
        logic [10:0] width_r;
        logic [10:0] chan_r;
        logic [2:0]  ksize_r;
        logic [1:0]  elog_r;
        logic [47:0] src_base_r;
        logic [47:0] dst_base_r;
        int          mismatches;
        int          checked;
        int          interior_seen;
        int          border_seen;

        function new();
            height_r   = 11'd1;
            width_r    = 11'd1;
            chan_r     = 11'd1;
            ksize_r    = 3'd3;
            elog_r     = 2'd0;
            src_base_r = '0;
            dst_base_r = '0;
        endfunction

        function void apply_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                REG_IMAGE_HEIGHT: height_r   = value[10:0];
                REG_IMAGE_WIDTH:  width_r    = value[10:0];
                REG_CHANNELS:     chan_r     = value[10:0];
                REG_KERNEL_SIZE:  ksize_r    = value[2:0];
                REG_ELEM_LOG2:    elog_r     = value[1:0];
                REG_SOURCE_BASE:  src_base_r = value[47:0];
                REG_DEST_BASE:    dst_base_r = value[47:0];
                default: ;
            endcase
        endfunction

        // expands one output position into the descriptors of its im2row row
        function void note_position(pos_t p);
            longint    hh, ww, hs, ws, pad, side, i, j, r, c;
            bit [63:0] b, cc, rowlen, pix, dst, elem;
            int        sh;
            desc_t     d;
            b   = 64'(p.batch_index);
            hh  = longint'(p.out_row);
            ww  = longint'(p.out_col);
            hs  = (height_r > MAX_DIM) ? MAX_DIM : longint'(height_r);
            ws  = (width_r > MAX_DIM) ? MAX_DIM : longint'(width_r);
            cc  = (chan_r > MAX_CHANNELS) ? MAX_CHANNELS : 64'(chan_r);
            sh  = int'(elog_r);
            pad = (ksize_r != 0) ? (longint'(ksize_r) - 1) / 2 : 0;
            if (pad > (MAX_KERNEL - 1) / 2)
                pad = (MAX_KERNEL - 1) / 2;
            side   = 2 * pad + 1;
            rowlen = 64'(side * side) * cc;
            pix    = cc << sh;
            dst    = ((b * 64'(hs) + 64'(hh)) * 64'(ws) + 64'(ww)) * rowlen;
            dst    = 64'(dst_base_r) + (dst << sh);
            if (hh >= pad && hh < hs - pad && ww >= pad && ww < ws - pad)
            begin
                interior_seen++;
                // one contiguous run per kernel row
                for (i = -pad; i <= pad; i++)
                begin
                    elem = ((b * 64'(hs) + 64'(hh + i)) * 64'(ws) + 64'(ww - pad)) * cc;
                    d.src_addr     = 48'(64'(src_base_r) + (elem << sh));
                    d.dst_addr     = dst[47:0];
                    d.length_bytes = 16'(64'(side) * pix);
                    d.zero_fill    = 1'b0;
                    d.last         = (i == pad);
                    due_descs.push_back(d);
                    dst += 64'(side) * pix;
                end
            end
            else
            begin
                border_seen++;
                for (i = -pad; i <= pad; i++)
                begin
                    for (j = -pad; j <= pad; j++)
                    begin
                        r = hh + i;
                        c = ww + j;
                        if (r >= 0 && r < hs && c >= 0 && c < ws)
                        begin
                            elem = ((b * 64'(hs) + 64'(r)) * 64'(ws) + 64'(c)) * cc;
                            d.src_addr  = 48'(64'(src_base_r) + (elem << sh));
                            d.zero_fill = 1'b0;
                        end
                        else
                        begin
                            d.src_addr  = '0;
                            d.zero_fill = 1'b1;
                        end
                        d.dst_addr     = dst[47:0];
                        d.length_bytes = pix[15:0];
                        d.last         = (i == pad && j == pad);
                        due_descs.push_back(d);
                        dst += pix;
                    end
                end
            end
        endfunction

        function void check_descriptor(desc_t got);
            desc_t want;
            checked++;
            if (due_descs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: descriptor with none expected: src %h dst %h len %0d",
                             $time, got.src_addr, got.dst_addr, got.length_bytes);
                return;
            end
            want = due_descs.pop_front();
            if (got.src_addr !== want.src_addr || got.dst_addr !== want.dst_addr ||
                got.length_bytes !== want.length_bytes ||
                got.zero_fill !== want.zero_fill || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: expected src %h dst %h len %0d zero %0b last %0b",
                             $time, want.src_addr, want.dst_addr, want.length_bytes,
                             want.zero_fill, want.last);
                    $display("%0t: actual   src %h dst %h len %0d zero %0b last %0b",
                             $time, got.src_addr, got.dst_addr, got.length_bytes,
                             got.zero_fill, got.last);
                end
            end
        endfunction

        function int outstanding();
            return due_descs.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        pos_valid;
    logic        pos_ready;
    pos_t        pos;
    logic        desc_valid;
    logic        desc_ready = 1'b0;
    desc_t       desc;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    desc_scoreboard board;
    ready_mode_e    stall_mode = READY_ALWAYS;
    int             cycle_count = 0;
    int             idle_cycles = 0;
    int             burst_left = 0;
    int             positions_sent = 0;
    int             settings_used = 0;

    im2row_copy_descriptor_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pos_valid  (pos_valid),
        .pos_ready  (pos_ready),
        .pos        (pos),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #6 clk = ~clk;

    // receiver stalls follow a mode drawn at random from always, random and periodic ready
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 97 == 0)
            stall_mode <= ready_mode_e'($urandom_range(0, 2));
        case (stall_mode)
            READY_ALWAYS: desc_ready <= 1'b1;
            READY_RANDOM: desc_ready <= ($urandom_range(0, 3) != 0);
            default:      desc_ready <= (cycle_count % 11) >= 6;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (pos_valid && pos_ready)
                board.note_position(pos);
            if (desc_valid && desc_ready)
                board.check_descriptor(desc);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (pos_valid && pos_ready) || (desc_valid && desc_ready) ||
            (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    function automatic pos_t position_of(int b, int r, int c);
        pos_t p;
        p.batch_index = b[7:0];
        p.out_row     = r[9:0];
        p.out_col     = c[9:0];
        return p;
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value,
                             input int width, input bit dirty);
        logic [63:0] wr;
        wr = value;
        // junk above the register width must be dropped
        if (dirty && width < 64)
            wr = wr | ({$urandom(), $urandom()} << width);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= wr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.apply_reg(idx, wr);
    endtask

    task automatic wait_drained();
        pos_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (board.outstanding() != 0);
    endtask

    task automatic program_geometry(input int h, input int w, input int c, input int k,
                                    input int es, input logic [47:0] sbase,
                                    input logic [47:0] dbase, input bit dirty);
        wait_drained();
        apb_write(REG_IMAGE_HEIGHT, 64'(h), 11, dirty);
        apb_write(REG_IMAGE_WIDTH, 64'(w), 11, dirty);
        apb_write(REG_CHANNELS, 64'(c), 11, dirty);
        apb_write(REG_KERNEL_SIZE, 64'(k), 3, dirty);
        apb_write(REG_ELEM_LOG2, 64'(es), 2, dirty);
        apb_write(REG_SOURCE_BASE, 64'(sbase), 48, dirty);
        apb_write(REG_DEST_BASE, 64'(dbase), 48, dirty);
        settings_used++;
    endtask

    // sender works in bursts; a nonzero gap drops valid before the next burst
    task automatic send_position(input pos_t p);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                pos_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        pos_valid <= 1'b1;
        pos       <= p;
        @(posedge clk);
        while (!pos_ready) @(posedge clk);
        burst_left--;
        positions_sent++;
    endtask

    initial
    begin
        int   ph;
        int   n;
        int   h;
        int   w;
        int   c;
        int   k;
        int   hs;
        int   ws;
        pos_t p;

        board     = new();
        rst_n     = 1'b0;
        pos_valid = 1'b0;
        pos       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: 1x1x1 image with a 3x3 kernel
        send_position(position_of(0, 0, 0));
        send_position(position_of(255, 1023, 1023));

        program_geometry(5, 6, 3, 3, 1, rand48(), rand48(), 1'b0);
        apb_write(REG_UNUSED, {$urandom(), $urandom()}, 64, 1'b0);
        send_position(position_of(0, 0, 0));
        send_position(position_of(1, 2, 3));
        send_position(position_of(2, 4, 5));
        send_position(position_of(255, 2, 0));
        send_position(position_of(7, 1023, 1023));
        send_position(position_of(0, 3, 1023));

        // widest kernel with the largest pixel, full 16-bit length on interior rows
        program_geometry(8, 9, 1024, 7, 3, rand48(), rand48(), 1'b0);
        send_position(position_of(1, 3, 4));
        send_position(position_of(0, 0, 8));

        // even kernel sizes round down to odd and a zero size acts as 1
        program_geometry(2, 2, 5, 0, 2, rand48(), rand48(), 1'b0);
        send_position(position_of(3, 1, 1));
        program_geometry(2, 2, 5, 2, 0, rand48(), rand48(), 1'b0);
        send_position(position_of(0, 0, 0));
        program_geometry(4, 4, 5, 4, 1, rand48(), rand48(), 1'b0);
        send_position(position_of(1, 1, 1));
        program_geometry(4, 4, 5, 6, 2, rand48(), rand48(), 1'b0);
        send_position(position_of(0, 2, 2));

        // oversized registers clamp to the maximum dimensions
        program_geometry(2047, 1500, 2047, 1, 3, rand48(), rand48(), 1'b0);
        send_position(position_of(255, 1023, 1023));
        send_position(position_of(0, 0, 0));
        program_geometry(2047, 1500, 2047, 5, 2, rand48(), rand48(), 1'b0);
        send_position(position_of(128, 512, 1023));

        // empty image and empty pixels
        program_geometry(0, 3, 2, 3, 0, rand48(), rand48(), 1'b0);
        send_position(position_of(0, 0, 1));
        send_position(position_of(9, 0, 0));
        program_geometry(3, 3, 0, 3, 1, rand48(), rand48(), 1'b0);
        send_position(position_of(1, 1, 1));
        send_position(position_of(0, 0, 0));

        // bases near the top of the address space wrap around
        program_geometry(1024, 1024, 64, 3, 3, 48'hFFFF_FFFF_FFF0, 48'hFFFF_FFFF_FFFF, 1'b0);
        send_position(position_of(255, 1023, 1022));
        send_position(position_of(200, 500, 500));

        for (ph = 0; ph < 12; ph++)
        begin
            case ($urandom_range(0, 9))
                0:       h = $urandom_range(1000, 2047);
                1:       h = $urandom_range(0, 2);
                default: h = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(1000, 2047);
                1:       w = $urandom_range(0, 2);
                default: w = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 7))
                0:       c = $urandom_range(0, 2047);
                default: c = $urandom_range(1, 16);
            endcase
            k = ($urandom_range(0, 1) == 0) ? 3 : $urandom_range(0, 7);
            program_geometry(h, w, c, k, $urandom_range(0, 3), rand48(), rand48(),
                             ph % 3 == 1);
            hs = (h > MAX_DIM) ? MAX_DIM : h;
            ws = (w > MAX_DIM) ? MAX_DIM : w;
            for (n = 0; n < 28; n++)
            begin
                p.batch_index = 8'($urandom_range(0, 255));
                if (hs == 0 || ws == 0 || $urandom_range(0, 6) == 0)
                begin
                    p.out_row = 10'($urandom_range(0, 1023));
                    p.out_col = 10'($urandom_range(0, 1023));
                end
                else
                begin
                    p.out_row = 10'($urandom_range(0, hs - 1));
                    p.out_col = 10'($urandom_range(0, ws - 1));
                end
                send_position(p);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d descriptors from %0d positions (%0d interior, %0d border)",
                 board.checked, positions_sent, board.interior_seen, board.border_seen);
        $display("over %0d register settings; %0d mismatches, %0d descriptors missing",
                 settings_used + 1, board.mismatches, board.outstanding());
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
